@@ rtl/hgpg_pkg.sv @@
// Shared types, constants and helpers of the hemisphere grid point generator.
// No dependencies; the files that use it refer to it by scoped names.
package hgpg_pkg;

  localparam int QUARTER_TURN = 23040;
  localparam int FULL_TURN    = 92160;
  localparam int MIN_RADIUS   = 10000;

  // Q30 radians per 1/256 degree, scaled by 2^16
  localparam logic [32:0] ANGLE_TO_Q30 = 33'd4797524517;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [2:0] {
    REG_RADIUS     = 3'd0,
    REG_AZ_POINTS  = 3'd1,
    REG_POL_POINTS = 3'd2,
    REG_POL_MIN    = 3'd3,
    REG_POL_MAX    = 3'd4
  } cfg_reg_e;

  // normalized settings
  typedef struct packed {
    logic [20:0] radius;
    logic [12:0] h;
    logic [12:0] v;
    logic [14:0] pmin;
    logic [14:0] span;
    logic        v_one;
  } cfg_t;

  typedef struct packed {
    logic err;
    logic last;
  } flag_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic [14:0] rem;
  } angle_t;

  typedef struct packed {
    flag_t       flags;
    logic [16:0] az;
    logic [14:0] pol;
  } cord_side_t;

  function automatic logic [14:0] clamp_polar(input logic signed [16:0] v);
    logic [14:0] res;
    if (v < 17'sd0) begin
      res = 15'd0;
    end else if (v > 17'(QUARTER_TURN)) begin
      res = 15'(QUARTER_TURN);
    end else begin
      res = v[14:0];
    end
    return res;
  endfunction

  function automatic angle_t split_angle(input logic [16:0] a);
    angle_t res;
    if (a >= 17'(3 * QUARTER_TURN)) begin
      res.quad = 2'd3;
      res.rem  = 15'(a - 17'(3 * QUARTER_TURN));
    end else if (a >= 17'(2 * QUARTER_TURN)) begin
      res.quad = 2'd2;
      res.rem  = 15'(a - 17'(2 * QUARTER_TURN));
    end else if (a >= 17'(QUARTER_TURN)) begin
      res.quad = 2'd1;
      res.rem  = 15'(a - 17'(QUARTER_TURN));
    end else begin
      res.quad = 2'd0;
      res.rem  = a[14:0];
    end
    return res;
  endfunction

  // round half up, then drop 30 fraction bits
  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

endpackage

@@ rtl/hgpg_in_if.sv @@
// Input channel of the grid point generator: one point index per word.
// Depends on nothing.
interface hgpg_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] point_index;

  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

@@ rtl/hgpg_out_if.sv @@
// Output channel of the grid point generator: angles and position per word.
// Depends on nothing.
interface hgpg_out_if;
  logic               valid;
  logic               ready;
  logic        [16:0] azimuth_angle;
  logic        [14:0] polar_angle;
  logic signed [21:0] pos_x;
  logic signed [21:0] pos_y;
  logic        [20:0] pos_z;
  logic               last_point;
  logic               index_error;

  modport source (output valid, output azimuth_angle, output polar_angle, output pos_x,
                  output pos_y, output pos_z, output last_point, output index_error,
                  input ready);
  modport sink   (input valid, input azimuth_angle, input polar_angle, input pos_x,
                  input pos_y, input pos_z, input last_point, input index_error,
                  output ready);
endinterface

@@ rtl/hgpg_cfg.sv @@
// Configuration registers and their normalization (floor, clamp, swap).
// Depends on hgpg_pkg.
module hgpg_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i,
  output hgpg_pkg::cfg_t     cfg_o
);

  logic [20:0] radius_q;
  logic [12:0] az_pts_q;
  logic [12:0] pol_pts_q;
  logic [16:0] pmin_q;
  logic [16:0] pmax_q;
  logic [14:0] lim_a;
  logic [14:0] lim_b;
  logic [14:0] lo;
  logic [14:0] hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 21'd100000;
      az_pts_q  <= 13'd1;
      pol_pts_q <= 13'd1;
      pmin_q    <= 17'd0;
      pmax_q    <= 17'(hgpg_pkg::QUARTER_TURN);
    end else if (cfg_we_i) begin
      unique case (hgpg_pkg::cfg_reg_e'(cfg_index_i))
        hgpg_pkg::REG_RADIUS:     radius_q  <= cfg_data_i;
        hgpg_pkg::REG_AZ_POINTS:  az_pts_q  <= cfg_data_i[12:0];
        hgpg_pkg::REG_POL_POINTS: pol_pts_q <= cfg_data_i[12:0];
        hgpg_pkg::REG_POL_MIN:    pmin_q    <= cfg_data_i[16:0];
        hgpg_pkg::REG_POL_MAX:    pmax_q    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lim_a = hgpg_pkg::clamp_polar(signed'(pmin_q));
    lim_b = hgpg_pkg::clamp_polar(signed'(pmax_q));
    lo    = (lim_a > lim_b) ? lim_b : lim_a;
    hi    = (lim_a > lim_b) ? lim_a : lim_b;

    cfg_o.radius = (radius_q < 21'(hgpg_pkg::MIN_RADIUS)) ?
                   21'(hgpg_pkg::MIN_RADIUS) : radius_q;
    cfg_o.h      = (az_pts_q == 13'd0) ? 13'd1 : az_pts_q;
    cfg_o.v      = (pol_pts_q == 13'd0) ? 13'd1 : pol_pts_q;
    cfg_o.pmin   = lo;
    cfg_o.span   = hi - lo;
    cfg_o.v_one  = (pol_pts_q == 13'd0) || (pol_pts_q == 13'd1);
  end

endmodule

@@ rtl/hgpg_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the numerator must satisfy num >> QUO_W < den.
module hgpg_div #(
  parameter int  NUM_W  = 24,
  parameter int  DEN_W  = 13,
  parameter int  QUO_W  = 24,
  parameter type SIDE_T = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  SIDE_T            side_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output SIDE_T            side_o
);

  logic [QUO_W-1:0] vld_q;
  logic [DEN_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  SIDE_T            side_q [QUO_W];

  logic [DEN_W-1:0] rem_in  [QUO_W];
  logic [QUO_W-1:0] quo_in  [QUO_W];
  logic [DEN_W-1:0] den_in  [QUO_W];
  SIDE_T            side_in [QUO_W];
  logic [DEN_W-1:0] rem_d   [QUO_W];
  logic [QUO_W-1:0] quo_d   [QUO_W];

  always_comb begin
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    rem_in[0]  = DEN_W'(num_i >> QUO_W);
    quo_in[0]  = num_i[QUO_W-1:0];
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int s = 1; s < QUO_W; s++) begin
      rem_in[s]  = rem_q[s-1];
      quo_in[s]  = quo_q[s-1];
      den_in[s]  = den_q[s-1];
      side_in[s] = side_q[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      trial    = {rem_in[s], quo_in[s][QUO_W-1]};
      diff     = trial - {1'b0, den_in[s]};
      ge       = (trial >= {1'b0, den_in[s]});
      rem_d[s] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d[s] = {quo_in[s][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[QUO_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < QUO_W; s++) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign rem_o  = rem_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

@@ rtl/hgpg_cordic.sv @@
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, then a
// quadrant map stage. Depends on hgpg_pkg for the gain and arctangent table.
module hgpg_cordic #(
  parameter int  STAGES = 20,
  parameter type SIDE_T = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  logic signed [31:0] z_i,
  input  logic [1:0]         quad_i,
  input  SIDE_T              side_i,
  output logic               vld_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o,
  output SIDE_T              side_o
);

  logic [STAGES-1:0]  vld_q;
  logic signed [31:0] x_q    [STAGES];
  logic signed [31:0] y_q    [STAGES];
  logic signed [31:0] z_q    [STAGES];
  logic [1:0]         quad_q [STAGES];
  SIDE_T              side_q [STAGES];

  logic signed [31:0] x_in    [STAGES];
  logic signed [31:0] y_in    [STAGES];
  logic signed [31:0] z_in    [STAGES];
  logic [1:0]         quad_in [STAGES];
  SIDE_T              side_in [STAGES];
  logic signed [31:0] x_d     [STAGES];
  logic signed [31:0] y_d     [STAGES];
  logic signed [31:0] z_d     [STAGES];

  logic               map_vld_q;
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  SIDE_T              map_side_q;
  logic signed [31:0] cos_d;
  logic signed [31:0] sin_d;

  always_comb begin
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] at;
    x_in[0]    = hgpg_pkg::CORDIC_GAIN_Q30;
    y_in[0]    = 32'sd0;
    z_in[0]    = z_i;
    quad_in[0] = quad_i;
    side_in[0] = side_i;
    for (int s = 1; s < STAGES; s++) begin
      x_in[s]    = x_q[s-1];
      y_in[s]    = y_q[s-1];
      z_in[s]    = z_q[s-1];
      quad_in[s] = quad_q[s-1];
      side_in[s] = side_q[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      dx = y_in[s] >>> s;
      dy = x_in[s] >>> s;
      at = signed'(hgpg_pkg::ATAN_Q30[s]);
      if (!z_in[s][31]) begin
        x_d[s] = x_in[s] - dx;
        y_d[s] = y_in[s] + dy;
        z_d[s] = z_in[s] - at;
      end else begin
        x_d[s] = x_in[s] + dx;
        y_d[s] = y_in[s] - dy;
        z_d[s] = z_in[s] + at;
      end
    end
  end

  // fold the first-quadrant result back to the full circle
  always_comb begin
    unique case (quad_q[STAGES-1])
      2'd0: begin cos_d = x_q[STAGES-1];  sin_d = y_q[STAGES-1];  end
      2'd1: begin cos_d = -y_q[STAGES-1]; sin_d = x_q[STAGES-1];  end
      2'd2: begin cos_d = -x_q[STAGES-1]; sin_d = -y_q[STAGES-1]; end
      default: begin cos_d = y_q[STAGES-1]; sin_d = -x_q[STAGES-1]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      map_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[STAGES-2:0], vld_i};
      map_vld_q <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < STAGES; s++) begin
        x_q[s]    <= x_d[s];
        y_q[s]    <= y_d[s];
        z_q[s]    <= z_d[s];
        quad_q[s] <= quad_in[s];
        side_q[s] <= side_in[s];
      end
      cos_q      <= cos_d;
      sin_q      <= sin_d;
      map_side_q <= side_q[STAGES-1];
    end
  end

  assign vld_o  = map_vld_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign side_o = map_side_q;

endmodule

@@ rtl/hemisphere_grid_point_generator.sv @@
// Hemisphere grid point generator: top level with the point pipeline.
// Depends on hgpg_pkg, hgpg_in_if, hgpg_out_if, hgpg_cfg, hgpg_div, hgpg_cordic.
//
// Usage:
//   in_i carries one grid index per word (row * azimuth_points + column);
//   out_o returns one word per index: azimuth, polar angle, x/y/z in um and
//   the last_point / index_error flags. Handshake on both sides is
//   valid/ready; a word moves at a clock edge with both high.
//   Settings are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   the pipeline is empty; indexes 5..7 are ignored.
// Pipeline stages from input to output:
//   24 stages for index / azimuth_points, one for the numerators, 17 for the
//   two rounding divisions, two for quadrant fold and angle scaling, the
//   CORDIC chain plus its quadrant stage, three multiply/round stages and
//   the output register.
// Throughput: one word per cycle unless stalled; all stages advance together.
// Reset clears all valid bits and loads the default settings.
// Stall: while out_o holds a word that is not taken, the whole pipeline
//   freezes and in_i.ready drops; nothing is lost or repeated.
module hemisphere_grid_point_generator #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  hgpg_in_if.sink     in_i,
  hgpg_out_if.source  out_o
);

  hgpg_pkg::cfg_t cfg;
  logic           adv;

  // entry: grid size check
  logic [25:0]     total;
  hgpg_pkg::flag_t in_flags;

  // index divider
  logic            a_vld;
  logic [23:0]     a_row;
  logic [12:0]     a_col;
  hgpg_pkg::flag_t a_flags;

  // numerator stage
  logic            b_vld_q;
  logic [30:0]     b_az_num_q;
  logic [28:0]     b_pol_num_q;
  hgpg_pkg::flag_t b_flags_q;

  // rounding dividers
  logic            c_vld;
  logic [16:0]     c_az;
  logic [16:0]     c_pol;
  hgpg_pkg::flag_t c_flags;

  // quadrant fold
  logic             d_vld_q;
  logic [16:0]      d_az_q;
  logic [14:0]      d_pol_q;
  hgpg_pkg::angle_t d_az_sp_q;
  hgpg_pkg::angle_t d_pol_sp_q;
  hgpg_pkg::flag_t  d_flags_q;
  logic [14:0]      d_pol_d;

  // angle to Q30 radians
  logic                 e_vld_q;
  logic signed [31:0]   e_az_z_q;
  logic signed [31:0]   e_pol_z_q;
  logic [1:0]           e_az_quad_q;
  logic [1:0]           e_pol_quad_q;
  hgpg_pkg::cord_side_t e_side_q;
  logic [47:0]          az_zp;
  logic [47:0]          pol_zp;

  // CORDIC outputs
  logic                 k_vld;
  logic signed [31:0]   k_ca;
  logic signed [31:0]   k_sa;
  logic signed [31:0]   k_cp;
  logic signed [31:0]   k_sp;
  hgpg_pkg::cord_side_t k_side;

  // products and rounding
  logic                 f_vld_q;
  logic signed [63:0]   f_px_q;
  logic signed [63:0]   f_py_q;
  logic signed [31:0]   f_cp_q;
  hgpg_pkg::cord_side_t f_side_q;

  logic                 g_vld_q;
  logic signed [31:0]   g_sx_q;
  logic signed [31:0]   g_sy_q;
  logic signed [31:0]   g_cp_q;
  hgpg_pkg::cord_side_t g_side_q;
  logic signed [63:0]   g_sx_full;
  logic signed [63:0]   g_sy_full;

  logic                 h_vld_q;
  logic signed [53:0]   h_px_q;
  logic signed [53:0]   h_py_q;
  logic signed [53:0]   h_pz_q;
  hgpg_pkg::cord_side_t h_side_q;
  logic signed [21:0]   r_s;

  // output register
  logic               out_vld_q;
  logic [16:0]        out_az_q;
  logic [14:0]        out_pol_q;
  logic signed [21:0] out_x_q;
  logic signed [21:0] out_y_q;
  logic [20:0]        out_z_q;
  logic               out_last_q;
  logic               out_err_q;
  logic signed [63:0] t_x;
  logic signed [63:0] t_y;
  logic signed [63:0] t_z;
  logic signed [63:0] r_w;
  logic signed [21:0] x_d;
  logic signed [21:0] y_d;
  logic [20:0]        z_d;

  hgpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance everything when the output register is free or being drained.
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // Flag an index past the grid and the final point before splitting it.
  always_comb begin
    total         = 26'(cfg.h) * 26'(cfg.v);
    in_flags.err  = ({2'b00, in_i.point_index} >= total);
    in_flags.last = ({2'b00, in_i.point_index} == (total - 26'd1));
  end

  hgpg_div #(
    .NUM_W  (24),
    .DEN_W  (13),
    .QUO_W  (24),
    .SIDE_T (hgpg_pkg::flag_t)
  ) u_div_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_i.valid),
    .num_i  (in_i.point_index),
    .den_i  (cfg.h),
    .side_i (in_flags),
    .vld_o  (a_vld),
    .quo_o  (a_row),
    .rem_o  (a_col),
    .side_o (a_flags)
  );

  // Build the rounding numerators: 2*92160*col + H and 2*span*row + (V-1).
  // Row fits 13 bits whenever the index is inside the grid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_az_num_q  <= 31'(31'(a_col) * 31'(2 * hgpg_pkg::FULL_TURN)) + 31'(cfg.h);
      b_pol_num_q <= 29'(29'(a_row[12:0]) * 29'({cfg.span, 1'b0})) +
                     29'(cfg.v - 13'd1);
      b_flags_q   <= a_flags;
    end
  end

  hgpg_div #(
    .NUM_W  (31),
    .DEN_W  (14),
    .QUO_W  (17),
    .SIDE_T (hgpg_pkg::flag_t)
  ) u_div_az (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (b_vld_q),
    .num_i  (b_az_num_q),
    .den_i  ({cfg.h, 1'b0}),
    .side_i (b_flags_q),
    .vld_o  (c_vld),
    .quo_o  (c_az),
    .rem_o  (),
    .side_o (c_flags)
  );

  // Same depth as the azimuth divider; its valid and sideband go unused.
  hgpg_div #(
    .NUM_W  (29),
    .DEN_W  (14),
    .QUO_W  (17),
    .SIDE_T (logic)
  ) u_div_pol (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (b_vld_q),
    .num_i  (b_pol_num_q),
    .den_i  ({cfg.v - 13'd1, 1'b0}),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (c_pol),
    .rem_o  (),
    .side_o ()
  );

  // Single ring: hold the polar angle at the lower limit.
  assign d_pol_d = cfg.v_one ? cfg.pmin : cfg.pmin + c_pol[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_az_q     <= c_az;
      d_pol_q    <= d_pol_d;
      d_az_sp_q  <= hgpg_pkg::split_angle(c_az);
      d_pol_sp_q <= hgpg_pkg::split_angle({2'b00, d_pol_d});
      d_flags_q  <= c_flags;
    end
  end

  // Scale the in-quadrant remainder to Q30 radians, rounding half up.
  assign az_zp  = 48'(d_az_sp_q.rem) * 48'(hgpg_pkg::ANGLE_TO_Q30) + 48'd32768;
  assign pol_zp = 48'(d_pol_sp_q.rem) * 48'(hgpg_pkg::ANGLE_TO_Q30) + 48'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_az_z_q       <= signed'(az_zp[47:16]);
      e_pol_z_q      <= signed'(pol_zp[47:16]);
      e_az_quad_q    <= d_az_sp_q.quad;
      e_pol_quad_q   <= d_pol_sp_q.quad;
      e_side_q.flags <= d_flags_q;
      e_side_q.az    <= d_az_q;
      e_side_q.pol   <= d_pol_q;
    end
  end

  hgpg_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_T (hgpg_pkg::cord_side_t)
  ) u_cordic_az (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (e_vld_q),
    .z_i    (e_az_z_q),
    .quad_i (e_az_quad_q),
    .side_i (e_side_q),
    .vld_o  (k_vld),
    .cos_o  (k_ca),
    .sin_o  (k_sa),
    .side_o (k_side)
  );

  hgpg_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_T (logic)
  ) u_cordic_pol (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (e_vld_q),
    .z_i    (e_pol_z_q),
    .quad_i (e_pol_quad_q),
    .side_i (1'b0),
    .vld_o  (),
    .cos_o  (k_cp),
    .sin_o  (k_sp),
    .side_o ()
  );

  // sin(polar) * cos/sin(azimuth) in Q60
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= k_vld;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
    end
  end

  assign g_sx_full = hgpg_pkg::round_q30(f_px_q);
  assign g_sy_full = hgpg_pkg::round_q30(f_py_q);
  assign r_s       = signed'({1'b0, cfg.radius});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_px_q   <= 64'(k_sp) * 64'(k_ca);
      f_py_q   <= 64'(k_sp) * 64'(k_sa);
      f_cp_q   <= k_cp;
      f_side_q <= k_side;

      g_sx_q   <= g_sx_full[31:0];
      g_sy_q   <= g_sy_full[31:0];
      g_cp_q   <= f_cp_q;
      g_side_q <= f_side_q;

      h_px_q   <= 54'(r_s) * 54'(g_sx_q);
      h_py_q   <= 54'(r_s) * 54'(g_sy_q);
      h_pz_q   <= 54'(r_s) * 54'(g_cp_q);
      h_side_q <= g_side_q;
    end
  end

  // Round to um, then clamp x/y to -R..R and z to 0..R.
  always_comb begin
    t_x = hgpg_pkg::round_q30(64'(h_px_q));
    t_y = hgpg_pkg::round_q30(64'(h_py_q));
    t_z = hgpg_pkg::round_q30(64'(h_pz_q));
    r_w = 64'(r_s);
    if (t_x > r_w) begin
      x_d = r_s;
    end else if (t_x < -r_w) begin
      x_d = -r_s;
    end else begin
      x_d = t_x[21:0];
    end
    if (t_y > r_w) begin
      y_d = r_s;
    end else if (t_y < -r_w) begin
      y_d = -r_s;
    end else begin
      y_d = t_y[21:0];
    end
    if (t_z > r_w) begin
      z_d = cfg.radius;
    end else if (t_z < 64'sd0) begin
      z_d = 21'd0;
    end else begin
      z_d = t_z[20:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= h_vld_q;
    end
  end

  // Drop every field but the flag for an index past the grid.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_err_q <= h_side_q.flags.err;
      if (h_side_q.flags.err) begin
        out_az_q   <= '0;
        out_pol_q  <= '0;
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_z_q    <= '0;
        out_last_q <= 1'b0;
      end else begin
        out_az_q   <= h_side_q.az;
        out_pol_q  <= h_side_q.pol;
        out_x_q    <= x_d;
        out_y_q    <= y_d;
        out_z_q    <= z_d;
        out_last_q <= h_side_q.flags.last;
      end
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.azimuth_angle = out_az_q;
  assign out_o.polar_angle   = out_pol_q;
  assign out_o.pos_x         = out_x_q;
  assign out_o.pos_y         = out_y_q;
  assign out_o.pos_z         = out_z_q;
  assign out_o.last_point    = out_last_q;
  assign out_o.index_error   = out_err_q;

endmodule

@@ rtl/hgpg_checker.sv @@
// Port-level checks of the grid point generator, bound to its top level.
// Depends on hemisphere_grid_point_generator and its channel interfaces.
module hgpg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [16:0] azimuth_angle_i,
  input logic        [14:0] polar_angle_i,
  input logic signed [21:0] pos_x_i,
  input logic signed [21:0] pos_y_i,
  input logic        [20:0] pos_z_i,
  input logic               last_point_i,
  input logic               index_error_i
);

  // a waiting word stays valid and holds its position and azimuth angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pos_x_i) &&
    $stable(pos_y_i) && $stable(pos_z_i) && $stable(azimuth_angle_i))
    else $error("output word changed while stalled");

  // input backpressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && index_error_i |-> !last_point_i && pos_x_i == 22'sd0 &&
    pos_y_i == 22'sd0 && pos_z_i == 21'd0 && azimuth_angle_i == 17'd0 &&
    polar_angle_i == 15'd0)
    else $error("error word carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> azimuth_angle_i < 17'd92160 && polar_angle_i <= 15'd23040)
    else $error("angle out of range");

endmodule

bind hemisphere_grid_point_generator hgpg_checker u_hgpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .azimuth_angle_i (out_o.azimuth_angle),
  .polar_angle_i   (out_o.polar_angle),
  .pos_x_i         (out_o.pos_x),
  .pos_y_i         (out_o.pos_y),
  .pos_z_i         (out_o.pos_z),
  .last_point_i    (out_o.last_point),
  .index_error_i   (out_o.index_error)
);
